FILE: hw/rtl/heading_pi_steering_control_macros.svh
// assertion helpers for the heading pi steering control
`ifndef HEADING_PI_STEERING_CONTROL_MACROS_SVH
`define HEADING_PI_STEERING_CONTROL_MACROS_SVH

// same-cycle implication
`define HPSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hpsc assertion failed");

// next-cycle implication
`define HPSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hpsc assertion failed");

`endif

FILE: hw/rtl/hpsc_pkg.sv
`default_nettype none
package hpsc_pkg;

   localparam logic signed [13:0] WrapHalf    = 14'sd1800;
   localparam logic signed [13:0] WrapFull    = 14'sd3600;
   localparam logic signed [11:0] CircleLimit = 12'sd1350;

   localparam logic [11:0] ResetTarget      = 12'd0;
   localparam logic [7:0]  ResetGainP       = 8'd2;
   localparam logic [15:0] ResetGainI       = 16'd292;
   localparam logic [15:0] ResetServoCenter = 16'd2765;
   localparam logic [15:0] ResetServoMin    = 16'd1659;
   localparam logic [15:0] ResetServoMax    = 16'd3871;
   localparam logic [15:0] ResetMotorMin    = 16'd2028;
   localparam logic [15:0] ResetMotorMax    = 16'd3502;

   typedef enum logic [2:0] {
      CSR_TARGET_HEADING,
      CSR_GAIN_P,
      CSR_GAIN_I_Q16,
      CSR_STEER_MID,
      CSR_STEER_LOW,
      CSR_STEER_HIGH,
      CSR_DRIVE_LOW,
      CSR_DRIVE_HIGH
   } csr_index_type;

   typedef struct packed {
      logic [11:0] target_heading;
      logic [7:0]  gain_p;
      logic [15:0] gain_i_q16;
      logic [15:0] steer_mid;
      logic [15:0] steer_low;
      logic [15:0] steer_high;
      logic [15:0] drive_low;
      logic [15:0] drive_high;
   } cfg_type;

   typedef struct packed {
      logic signed [11:0] err;
      logic signed [31:0] integ;
   } error_type;

   typedef struct packed {
      logic signed [11:0] err;
      logic signed [19:0] p_term;
      logic signed [31:0] i_term;
   } term_type;

   typedef struct packed {
      logic [15:0]        steer_pulse;
      logic [15:0]        drive_pulse;
      logic               circling;
      logic signed [11:0] wrapped_error;
   } result_type;

endpackage
`default_nettype wire

FILE: hw/rtl/heading_pi_steering_control.sv
// heading pi steering control, four register stages: input, error/integral, products, result
// the result reaches the result register through the error/integral and products registers
// throughput: one beat per cycle when not stalled, set by the integral add and saturate
// each stage moves when it is empty or the next stage moves
// reset: control and integral clear to zero, csr registers take their default values
`default_nettype none
`include "heading_pi_steering_control_macros.svh"
module heading_pi_steering_control (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [11:0]        req_compass_heading,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [15:0]             rsp_steer_pulse,
   output logic [15:0]             rsp_drive_pulse,
   output logic                    rsp_circling,
   output logic signed [11:0]      rsp_wrapped_error,
   input  wire logic               csr_write_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   hpsc_pkg::cfg_type    cfg_ff;
   logic                 a_valid_ff;
   logic [11:0]          heading_a_ff;
   logic                 b_valid_ff;
   hpsc_pkg::error_type  error_b_ff;
   logic signed [31:0]   integral_ff;
   logic                 c_valid_ff;
   hpsc_pkg::term_type   term_c_ff;
   logic                 d_valid_ff;
   hpsc_pkg::result_type result_d_ff;

   hpsc_pkg::error_type  error_in;
   hpsc_pkg::term_type   term_in;
   hpsc_pkg::result_type result_in;

   logic adv_a;
   logic adv_b;
   logic adv_c;
   logic adv_d;

   assign adv_d     = !d_valid_ff || rsp_ready;
   assign adv_c     = !c_valid_ff || adv_d;
   assign adv_b     = !b_valid_ff || adv_c;
   assign adv_a     = !a_valid_ff || adv_b;
   assign req_ready = adv_a;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_heading <= hpsc_pkg::ResetTarget;
         cfg_ff.gain_p         <= hpsc_pkg::ResetGainP;
         cfg_ff.gain_i_q16     <= hpsc_pkg::ResetGainI;
         cfg_ff.steer_mid      <= hpsc_pkg::ResetServoCenter;
         cfg_ff.steer_low      <= hpsc_pkg::ResetServoMin;
         cfg_ff.steer_high     <= hpsc_pkg::ResetServoMax;
         cfg_ff.drive_low      <= hpsc_pkg::ResetMotorMin;
         cfg_ff.drive_high     <= hpsc_pkg::ResetMotorMax;
      end else if (csr_write_en) begin
         case (hpsc_pkg::csr_index_type'(csr_index))
            hpsc_pkg::CSR_TARGET_HEADING: cfg_ff.target_heading <= csr_data[11:0];
            hpsc_pkg::CSR_GAIN_P:         cfg_ff.gain_p         <= csr_data[7:0];
            hpsc_pkg::CSR_GAIN_I_Q16:     cfg_ff.gain_i_q16     <= csr_data;
            hpsc_pkg::CSR_STEER_MID:      cfg_ff.steer_mid      <= csr_data;
            hpsc_pkg::CSR_STEER_LOW:      cfg_ff.steer_low      <= csr_data;
            hpsc_pkg::CSR_STEER_HIGH:     cfg_ff.steer_high     <= csr_data;
            hpsc_pkg::CSR_DRIVE_LOW:      cfg_ff.drive_low      <= csr_data;
            hpsc_pkg::CSR_DRIVE_HIGH:     cfg_ff.drive_high     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   hpsc_error u_error (
      .target_heading (cfg_ff.target_heading),
      .heading        (heading_a_ff),
      .integral       (integral_ff),
      .error_out      (error_in)
   );

   hpsc_term u_term (
      .gain_p     (cfg_ff.gain_p),
      .gain_i_q16 (cfg_ff.gain_i_q16),
      .error_in   (error_b_ff),
      .term_out   (term_in)
   );

   hpsc_shape u_shape (
      .cfg        (cfg_ff),
      .term_in    (term_c_ff),
      .result_out (result_in)
   );

   // valid bits and integral
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         c_valid_ff  <= 1'b0;
         d_valid_ff  <= 1'b0;
         integral_ff <= '0;
      end else begin
         if (adv_a) begin
            a_valid_ff <= req_valid;
         end
         if (adv_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (adv_c) begin
            c_valid_ff <= b_valid_ff;
         end
         if (adv_d) begin
            d_valid_ff <= c_valid_ff;
         end
         if (adv_b && a_valid_ff) begin
            integral_ff <= error_in.integ;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv_a && req_valid) begin
         heading_a_ff <= req_compass_heading;
      end
      if (adv_b && a_valid_ff) begin
         error_b_ff <= error_in;
      end
      if (adv_c && b_valid_ff) begin
         term_c_ff <= term_in;
      end
      if (adv_d && c_valid_ff) begin
         result_d_ff <= result_in;
      end
   end

   assign rsp_valid         = d_valid_ff;
   assign rsp_steer_pulse   = result_d_ff.steer_pulse;
   assign rsp_drive_pulse   = result_d_ff.drive_pulse;
   assign rsp_circling      = result_d_ff.circling;
   assign rsp_wrapped_error = result_d_ff.wrapped_error;

   `HPSC_ASSERT_NOW(a_circle_forces, clock, reset, d_valid_ff && result_d_ff.circling,
      result_d_ff.steer_pulse == cfg_ff.steer_high && result_d_ff.drive_pulse == cfg_ff.drive_low)
   `HPSC_ASSERT_NOW(a_error_range, clock, reset, d_valid_ff,
      result_d_ff.wrapped_error <= 12'sd1800 && result_d_ff.wrapped_error >= -12'sd1800)
   `HPSC_ASSERT_NOW(a_steer_clamped, clock, reset,
      d_valid_ff && !result_d_ff.circling && cfg_ff.steer_low <= cfg_ff.steer_high,
      result_d_ff.steer_pulse >= cfg_ff.steer_low && result_d_ff.steer_pulse <= cfg_ff.steer_high)
   `HPSC_ASSERT_NEXT(a_integral_hold, clock, reset, !(adv_b && a_valid_ff),
      $stable(integral_ff))

endmodule
`default_nettype wire

FILE: hw/rtl/hpsc_error.sv
`default_nettype none
module hpsc_error (
   input  wire logic [11:0]        target_heading,
   input  wire logic [11:0]        heading,
   input  wire logic signed [31:0] integral,
   output hpsc_pkg::error_type     error_out
);

   logic signed [13:0] diff;
   logic signed [13:0] wrapped;
   logic signed [32:0] sum;

   always_comb begin
      diff = $signed({2'b00, target_heading}) - $signed({2'b00, heading});
      if (diff > hpsc_pkg::WrapHalf) begin
         wrapped = diff - hpsc_pkg::WrapFull;
      end else if (diff < -hpsc_pkg::WrapHalf) begin
         wrapped = diff + hpsc_pkg::WrapFull;
      end else begin
         wrapped = diff;
      end
      sum = $signed({integral[31], integral}) + $signed({{21{wrapped[11]}}, wrapped[11:0]});
      error_out.err = wrapped[11:0];
      // saturate to 32 bits
      if (sum[32] != sum[31]) begin
         error_out.integ = sum[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end else begin
         error_out.integ = sum[31:0];
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/hpsc_term.sv
`default_nettype none
module hpsc_term (
   input  wire logic [7:0]          gain_p,
   input  wire logic [15:0]         gain_i_q16,
   input  wire hpsc_pkg::error_type error_in,
   output hpsc_pkg::term_type       term_out
);

   logic signed [8:0]  gain_p_s;
   logic signed [16:0] gain_i_s;
   logic signed [20:0] p_prod;
   logic signed [48:0] i_prod;

   always_comb begin
      gain_p_s = $signed({1'b0, gain_p});
      gain_i_s = $signed({1'b0, gain_i_q16});
      p_prod   = gain_p_s * error_in.err;
      i_prod   = gain_i_s * error_in.integ;
      term_out.err    = error_in.err;
      term_out.p_term = p_prod[19:0];
      // arithmetic shift gives the floor of the q16 product
      term_out.i_term = i_prod[47:16];
   end

endmodule
`default_nettype wire

FILE: hw/rtl/hpsc_shape.sv
`default_nettype none
module hpsc_shape (
   input  wire hpsc_pkg::cfg_type  cfg,
   input  wire hpsc_pkg::term_type term_in,
   output hpsc_pkg::result_type    result_out
);

   logic signed [33:0] pulse;
   logic signed [33:0] max_s;
   logic signed [33:0] min_s;
   logic [15:0]        clamped;
   logic               circle;

   always_comb begin
      pulse = $signed({18'b0, cfg.steer_mid})
            - $signed({{14{term_in.p_term[19]}}, term_in.p_term})
            - $signed({{2{term_in.i_term[31]}}, term_in.i_term});
      max_s = $signed({18'b0, cfg.steer_high});
      min_s = $signed({18'b0, cfg.steer_low});
      if (pulse > max_s) begin
         clamped = cfg.steer_high;
      end else if (pulse < min_s) begin
         clamped = cfg.steer_low;
      end else begin
         clamped = pulse[15:0];
      end
      circle = (term_in.err >= hpsc_pkg::CircleLimit)
            || (term_in.err <= -hpsc_pkg::CircleLimit);
      result_out.circling      = circle;
      result_out.steer_pulse   = circle ? cfg.steer_high : clamped;
      result_out.drive_pulse   = circle ? cfg.drive_low : cfg.drive_high;
      result_out.wrapped_error = term_in.err;
   end

endmodule
`default_nettype wire

FILE: test/heading_pi_steering_control_checker.sv
module heading_pi_steering_control_checker
   import hpsc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [11:0]        req_compass_heading,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [15:0]        rsp_steer_pulse,
   input  logic [15:0]        rsp_drive_pulse,
   input  logic               rsp_circling,
   input  logic signed [11:0] rsp_wrapped_error,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output int                 fail_count,
   output int                 outstanding
);

   localparam longint SumMax = 64'sd2147483647;
   localparam longint SumMin = -SumMax - 1;

   cfg_type            setting;
   logic signed [31:0] heading_error_sum;
   result_type         expected_steering[$];

   function automatic result_type steer_for_heading(input logic [11:0] heading);
      logic signed [13:0] err;
      longint             sum;
      longint             pulse;
      result_type         r;
      err = $signed({2'b00, setting.target_heading}) - $signed({2'b00, heading});
      if (err > WrapHalf) begin
         err = err - WrapFull;
      end else if (err < -WrapHalf) begin
         err = err + WrapFull;
      end
      sum = longint'(heading_error_sum) + longint'(err);
      if (sum > SumMax) begin
         sum = SumMax;
      end else if (sum < SumMin) begin
         sum = SumMin;
      end
      heading_error_sum = 32'(sum);
      // arithmetic shift of the q16 product rounds toward minus infinity
      pulse = longint'(setting.steer_mid) - longint'(setting.gain_p) * longint'(err)
            - ((longint'(setting.gain_i_q16) * sum) >>> 16);
      if (pulse > longint'(setting.steer_high)) begin
         r.steer_pulse = setting.steer_high;
      end else if (pulse < longint'(setting.steer_low)) begin
         r.steer_pulse = setting.steer_low;
      end else begin
         r.steer_pulse = pulse[15:0];
      end
      if (err >= CircleLimit || err <= -CircleLimit) begin
         r.steer_pulse = setting.steer_high;
         r.drive_pulse = setting.drive_low;
         r.circling    = 1'b1;
      end else begin
         r.drive_pulse = setting.drive_high;
         r.circling    = 1'b0;
      end
      r.wrapped_error = err[11:0];
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         setting = '{target_heading: ResetTarget, gain_p: ResetGainP,
                     gain_i_q16: ResetGainI, steer_mid: ResetServoCenter,
                     steer_low: ResetServoMin, steer_high: ResetServoMax,
                     drive_low: ResetMotorMin, drive_high: ResetMotorMax};
         heading_error_sum = '0;
         expected_steering.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_TARGET_HEADING: setting.target_heading = csr_data[11:0];
               CSR_GAIN_P:         setting.gain_p         = csr_data[7:0];
               CSR_GAIN_I_Q16:     setting.gain_i_q16     = csr_data;
               CSR_STEER_MID:      setting.steer_mid      = csr_data;
               CSR_STEER_LOW:      setting.steer_low      = csr_data;
               CSR_STEER_HIGH:     setting.steer_high     = csr_data;
               CSR_DRIVE_LOW:      setting.drive_low      = csr_data;
               CSR_DRIVE_HIGH:     setting.drive_high     = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_steering.size() == 0) begin
               flag_mismatch("result beat with nothing pending, steer",
                             int'(rsp_steer_pulse), 0);
            end else begin
               want = expected_steering.pop_front();
               if (rsp_steer_pulse !== want.steer_pulse)
                  flag_mismatch("steer_pulse", int'(rsp_steer_pulse), int'(want.steer_pulse));
               if (rsp_drive_pulse !== want.drive_pulse)
                  flag_mismatch("drive_pulse", int'(rsp_drive_pulse), int'(want.drive_pulse));
               if (rsp_circling !== want.circling)
                  flag_mismatch("circling", int'(rsp_circling), int'(want.circling));
               if (rsp_wrapped_error !== want.wrapped_error)
                  flag_mismatch("wrapped_error", int'(rsp_wrapped_error),
                                int'(want.wrapped_error));
            end
         end
         if (req_valid && req_ready) begin
            expected_steering.push_back(steer_for_heading(req_compass_heading));
         end
      end
      outstanding = expected_steering.size();
   end

endmodule

FILE: test/tb_heading_pi_steering_control.sv
module tb_heading_pi_steering_control;
   import hpsc_pkg::*;

   localparam int MixHeadings = 0;
   localparam int WindUp      = 1;
   localparam int HoldCycles  = 80;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [11:0]        req_compass_heading;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [15:0]        rsp_steer_pulse;
   logic [15:0]        rsp_drive_pulse;
   logic               rsp_circling;
   logic signed [11:0] rsp_wrapped_error;
   logic               csr_write_en;
   logic [2:0]         csr_index;
   logic [15:0]        csr_data;

   int      mismatches;
   int      pending;
   bit      calm;
   bit      hold_results;
   cfg_type live_cfg;

   // headings against a zero target: wrap limits, circle limits, out of range values
   logic [11:0] probe_default [16] = '{12'd0, 12'd1, 12'd1349, 12'd1350, 12'd1800, 12'd1801,
                                       12'd2249, 12'd2250, 12'd2251, 12'd3599, 12'd3600,
                                       12'd4095, 12'd2048, 12'd1365, 12'd2730, 12'd900};
   // headings against a target of 4095
   logic [11:0] probe_far [6] = '{12'd0, 12'd2295, 12'd2294, 12'd4095, 12'd2745, 12'd2746};

   heading_pi_steering_control u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_compass_heading (req_compass_heading),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_steer_pulse     (rsp_steer_pulse),
      .rsp_drive_pulse     (rsp_drive_pulse),
      .rsp_circling        (rsp_circling),
      .rsp_wrapped_error   (rsp_wrapped_error),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   heading_pi_steering_control_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_compass_heading (req_compass_heading),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_steer_pulse     (rsp_steer_pulse),
      .rsp_drive_pulse     (rsp_drive_pulse),
      .rsp_circling        (rsp_circling),
      .rsp_wrapped_error   (rsp_wrapped_error),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .fail_count          (mismatches),
      .outstanding         (pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_results) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_results = 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= 29);
         end
      end
   end

   function automatic logic [11:0] pick_heading(input logic [11:0] tgt);
      int off;
      case ($urandom_range(0, 9))
         0, 1, 2: return 12'($urandom_range(0, 3599));
         3:       return 12'($urandom_range(3600, 4095));
         4:       return 12'($urandom);
         5, 6:    off = int'($urandom_range(0, 200)) - 100;
         7:       off = 1348 + int'($urandom_range(0, 3));
         default: off = 1798 + int'($urandom_range(0, 4));
      endcase
      if ($urandom_range(0, 1)) off = -off;
      return 12'((int'(tgt) - off + 3600) % 3600);
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.target_heading = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                     : 12'($urandom_range(0, 3599));
      c.gain_p         = 8'($urandom);
      c.gain_i_q16     = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 2000));
      c.steer_mid      = 16'($urandom_range(1000, 5000));
      c.steer_low      = 16'($urandom_range(0, 3000));
      c.steer_high     = c.steer_low + 16'($urandom_range(0, 4000));
      c.drive_low      = 16'($urandom);
      c.drive_high     = 16'($urandom);
      return c;
   endfunction

   task automatic send_heading(input logic [11:0] heading);
      while (!calm && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_compass_heading <= heading;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic put_csr(input csr_index_type idx, input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(negedge clock);
   endtask

   // unused upper data bits carry noise
   task automatic apply_cfg(input cfg_type c);
      settle();
      live_cfg = c;
      put_csr(CSR_TARGET_HEADING, {4'($urandom), c.target_heading});
      put_csr(CSR_GAIN_P,         {8'($urandom), c.gain_p});
      put_csr(CSR_GAIN_I_Q16,     c.gain_i_q16);
      put_csr(CSR_STEER_MID,      c.steer_mid);
      put_csr(CSR_STEER_LOW,      c.steer_low);
      put_csr(CSR_STEER_HIGH,     c.steer_high);
      put_csr(CSR_DRIVE_LOW,      c.drive_low);
      put_csr(CSR_DRIVE_HIGH,     c.drive_high);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_items(input int count, input int mode);
      int off;
      for (int i = 0; i < count; i++) begin
         if (mode == WindUp) begin
            // long runs of large same-sign error drive the integral far out
            off = 1300 + int'($urandom_range(0, 49));
            if (i >= count / 2) off = -off;
            send_heading(12'((int'(live_cfg.target_heading) - off + 3600) % 3600));
         end else begin
            send_heading(pick_heading(live_cfg.target_heading));
         end
      end
   endtask

   initial begin
      cfg_type c;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_compass_heading = '0;
      csr_write_en        = 1'b0;
      csr_index           = '0;
      csr_data            = '0;
      calm                = 1'b0;
      hold_results        = 1'b0;
      live_cfg            = '{target_heading: ResetTarget, gain_p: ResetGainP,
                              gain_i_q16: ResetGainI, steer_mid: ResetServoCenter,
                              steer_low: ResetServoMin, steer_high: ResetServoMax,
                              drive_low: ResetMotorMin, drive_high: ResetMotorMax};
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (probe_default[i]) send_heading(probe_default[i]);

      // all registers at their top values but steer_low and drive_low, which are zero
      apply_cfg('{target_heading: 12'hFFF, gain_p: 8'hFF, gain_i_q16: 16'hFFFF,
                  steer_mid: 16'hFFFF, steer_low: 16'h0000, steer_high: 16'hFFFF,
                  drive_low: 16'h0000, drive_high: 16'hFFFF});
      foreach (probe_far[i]) send_heading(probe_far[i]);
      hold_results = 1'b1;
      run_items(220, MixHeadings);

      apply_cfg('0);
      run_items(150, MixHeadings);

      // low steer limit above high steer limit
      c            = random_cfg();
      c.steer_low  = 16'd40000;
      c.steer_high = 16'd1000;
      apply_cfg(c);
      run_items(200, MixHeadings);

      apply_cfg(random_cfg());
      calm = 1'b1;
      run_items(300, MixHeadings);
      calm = 1'b0;

      c                = random_cfg();
      c.target_heading = 12'($urandom_range(0, 3599));
      c.gain_i_q16     = 16'hFFFF;
      c.steer_low      = 16'h0000;
      c.steer_high     = 16'hFFFF;
      c.steer_mid      = 16'h8000;
      apply_cfg(c);
      run_items(500, WindUp);

      apply_cfg(random_cfg());
      run_items(250, MixHeadings);
      apply_cfg(random_cfg());
      run_items(250, MixHeadings);

      settle();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
